// ----- rtl/xpr_pkg.sv -----
`default_nettype none

package xpr_pkg;

  localparam int PacketBytes = 128;
  localparam int QueueDepth  = 2;

  localparam logic [7:0]  CODE_SOH = 8'h01;
  localparam logic [7:0]  CODE_EOT = 8'h04;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SUM_GOOD = 8'd255;

  localparam logic [1:0] EV_DATA = 2'd0;
  localparam logic [1:0] EV_GOOD = 2'd1;
  localparam logic [1:0] EV_BAD  = 2'd2;
  localparam logic [1:0] EV_END  = 2'd3;

  localparam logic [2:0] OP_BLOCK   = 3'd0;
  localparam logic [2:0] OP_INVERSE = 3'd1;
  localparam logic [2:0] OP_DATA    = 3'd2;
  localparam logic [2:0] OP_TRAIL1  = 3'd3;
  localparam logic [2:0] OP_TRAIL2  = 3'd4;
  localparam logic [2:0] OP_EOT     = 3'd5;

  typedef struct packed {
    logic [2:0] op_kind;
    logic       mode;
    logic [7:0] rx_byte;
    logic [6:0] index;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/xpr_front.sv -----
`default_nettype none

module xpr_front import xpr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       crc_mode,
  input  wire logic       q_full,
  output logic            push,
  output op_t             push_op
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_BLOCK  = 3'd1;
  localparam logic [2:0] PH_INV    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_TRAIL1 = 3'd4;
  localparam logic [2:0] PH_TRAIL2 = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [6:0] count_r, count_nxt;
  logic       accept;
  logic       emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_comb begin
    phase_nxt       = phase_r;
    count_nxt       = count_r;
    emit            = 1'b1;
    push_op.op_kind = OP_EOT;
    push_op.mode    = crc_mode;
    push_op.rx_byte = in_rx_byte;
    push_op.index   = count_r;
    unique case (phase_r)
      PH_BLOCK: begin
        push_op.op_kind = OP_BLOCK;
        phase_nxt       = PH_INV;
      end
      PH_INV: begin
        push_op.op_kind = OP_INVERSE;
        count_nxt       = '0;
        phase_nxt       = PH_DATA;
      end
      PH_DATA: begin
        push_op.op_kind = OP_DATA;
        count_nxt       = count_r + 7'd1;
        if (count_r == 7'(PacketBytes - 1)) begin
          phase_nxt = PH_TRAIL1;
        end
      end
      PH_TRAIL1: begin
        push_op.op_kind = OP_TRAIL1;
        phase_nxt       = crc_mode ? PH_TRAIL2 : PH_IDLE;
      end
      PH_TRAIL2: begin
        push_op.op_kind = OP_TRAIL2;
        phase_nxt       = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (in_rx_byte == CODE_SOH) begin
          phase_nxt = PH_BLOCK;
          emit      = 1'b0;
        end else if (in_rx_byte == CODE_EOT) begin
          push_op.op_kind = OP_EOT;
        end else begin
          emit = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/xpr_queue.sv -----
`default_nettype none

module xpr_queue import xpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  push_op,
  input  wire logic pop,
  output logic      full,
  output q_head_t   head
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  op_t             mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full       = (count_r == CntW'(QueueDepth));
  assign head.valid = (count_r != '0);
  assign head.op    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/xpr_back.sv -----
`default_nettype none

module xpr_back import xpr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_head_t head,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic [1:0]   out_event_kind,
  output logic [7:0]   out_data_byte,
  output logic [6:0]   out_byte_index
);

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [6:0]  index_r, index_nxt;
  logic [7:0]  block_sum_r, block_sum_nxt;
  logic [15:0] check_r, check_nxt;
  logic [7:0]  trail_hi_r, trail_hi_nxt;
  logic        emit;
  logic        good;
  op_t         op;

  assign op  = head.op;
  assign pop = head.valid && (!out_valid_r || out_ready);

  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_data_byte  = data_r;
  assign out_byte_index = index_r;

  always_comb begin
    block_sum_nxt = block_sum_r;
    check_nxt     = check_r;
    trail_hi_nxt  = trail_hi_r;
    emit          = 1'b0;
    good          = 1'b0;
    kind_nxt      = EV_END;
    data_nxt      = '0;
    index_nxt     = '0;
    unique case (op.op_kind)
      OP_BLOCK: begin
        block_sum_nxt = op.rx_byte;
      end
      OP_INVERSE: begin
        block_sum_nxt = block_sum_r + op.rx_byte;
        check_nxt     = '0;
      end
      OP_DATA: begin
        if (op.mode) begin
          check_nxt = crc_add_byte(check_r, op.rx_byte);
        end else begin
          check_nxt = {8'h00, check_r[7:0] + op.rx_byte};
        end
        emit      = 1'b1;
        kind_nxt  = EV_DATA;
        data_nxt  = op.rx_byte;
        index_nxt = op.index;
      end
      OP_TRAIL1: begin
        if (op.mode) begin
          trail_hi_nxt = op.rx_byte;
        end else begin
          good     = (op.rx_byte == check_r[7:0]) && (block_sum_r == SUM_GOOD);
          emit     = 1'b1;
          kind_nxt = good ? EV_GOOD : EV_BAD;
        end
      end
      OP_TRAIL2: begin
        good     = ({trail_hi_r, op.rx_byte} == check_r) && (block_sum_r == SUM_GOOD);
        emit     = 1'b1;
        kind_nxt = good ? EV_GOOD : EV_BAD;
      end
      default: begin
        emit     = 1'b1;
        kind_nxt = EV_END;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      block_sum_r <= block_sum_nxt;
      check_r     <= check_nxt;
      trail_hi_r  <= trail_hi_nxt;
      if (emit) begin
        kind_r  <= kind_nxt;
        data_r  <= data_nxt;
        index_r <= index_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/xmodem_packet_receiver.sv -----
// A byte accepted at the input is written into a queue entry and then into the output
// register before its result appears on the output ports.
// Throughput: one byte per cycle while the two-beat queue is not full; in_ready drops when it is.
// Reset is synchronous and active low; it empties the queue, returns the receiver to waiting
// for a start byte and sets the mode register to CRC.
`default_nettype none

module xmodem_packet_receiver import xpr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_event_kind,
  output logic [7:0]      out_data_byte,
  output logic [6:0]      out_byte_index,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata
);

  logic    crc_mode_r;
  logic    q_full;
  logic    push;
  op_t     push_op;
  logic    pop;
  q_head_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_mode_r <= 1'b1;
    end else if (cfg_we) begin
      crc_mode_r <= cfg_wdata;
    end
  end

  xpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .crc_mode   (crc_mode_r),
    .q_full     (q_full),
    .push       (push),
    .push_op    (push_op)
  );

  xpr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (q_full),
    .head    (head)
  );

  xpr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index)
  );

endmodule

`default_nettype wire
